// File: rtl/icf_pkg.sv
// Shared types, constants and the byte-wise CRC-24 update for the module image framer.
// No dependencies; used by icf_step and module_image_crc24_framer.
package icf_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned MAX_RESULTS  = 5;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned QCNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QIDX_W       = $clog2(MAX_RESULTS);

  localparam logic [CNT_W-1:0] HEADER_LEN = CNT_W'(HEADER_BYTES);
  localparam logic [23:0]      CRC_INIT   = 24'hFFFFFF;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_PARITY = 2'd1;
  localparam logic [1:0] KIND_CRC    = 2'd2;

  typedef struct packed {
    logic [23:0]      crc;
    logic [7:0]       parity;
    logic [CNT_W-1:0] count;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       eom;
  } result_t;

  // One byte folded into the running CRC. The top bit of the parity prefix
  // of a is simply the XOR of all bits of a.
  function automatic logic [23:0] crc_fold(input logic [23:0] crc, input logic [7:0] b);
    logic [7:0] a;
    logic [7:0] n0;
    logic [7:0] n1;
    logic [7:0] n2;
    a  = b ^ crc[23:16];
    n0 = crc[15:8];
    n1 = crc[7:0] ^ (a >> 7) ^ (a >> 2);
    n2 = (a << 1) ^ (a << 6);
    if (^a) begin
      n0 = n0 ^ 8'h80;
      n2 = n2 ^ 8'h21;
    end
    return {n0, n1, n2};
  endfunction

endpackage

// File: rtl/module_image_crc24_framer.sv
// Module image framer: passes bytes through, inserts the header parity byte and
// appends the inverted CRC-24. Depends on icf_pkg and icf_step.
//
// Usage: bytes enter on the in_valid/in_ready channel with first_byte and
// last_byte marks. Each input transaction yields one to five output
// transactions on out_valid/out_ready: the data byte, the inverted header
// parity byte after the eighth header byte, and three inverted CRC bytes,
// most significant first, after a last byte (end_of_module on the third).
// The data byte is presented from the queue in the cycle after its transaction.
// Throughput: one input byte per cycle while each byte yields one result and
// out_ready stays high; a byte with more results holds in_ready low while the
// single result queue drains, one entry per cycle while out_ready is high.
// in_ready is high when the queue is empty, or holds one entry that is
// taken in the same cycle. When the receiver stalls, the head result stays
// on the outputs unchanged and input stops once the queue is not draining.
// Reset empties the queue and sets the CRC to all ones, parity and header
// count to zero; a stream without a first byte starts from that state.
module module_image_crc24_framer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] byte_kind,
  output logic       end_of_module
);

  icf_pkg::state_t                state;
  icf_pkg::state_t                state_next;
  icf_pkg::result_t               step_results [icf_pkg::MAX_RESULTS];
  logic [icf_pkg::QCNT_W-1:0]     step_count;
  icf_pkg::result_t               queue [icf_pkg::MAX_RESULTS];
  logic [icf_pkg::QCNT_W-1:0]     qcount;
  logic                           pop;
  logic                           accept;

  icf_step u_step (
    .state       (state),
    .in_byte     (in_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .state_next  (state_next),
    .results     (step_results),
    .num_results (step_count)
  );

  assign out_valid     = (qcount != '0);
  assign pop           = out_valid && out_ready;
  assign in_ready      = (qcount == '0) || ((qcount == icf_pkg::QCNT_W'(1)) && out_ready);
  assign accept        = in_valid && in_ready;
  assign out_byte      = queue[0].data;
  assign byte_kind     = queue[0].kind;
  assign end_of_module = queue[0].eom;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.crc    <= icf_pkg::CRC_INIT;
      state.parity <= 8'h00;
      state.count  <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= '0;
    end else if (accept) begin
      qcount <= step_count;
    end else if (pop) begin
      qcount <= qcount - icf_pkg::QCNT_W'(1);
    end
  end

  // A new transaction is only taken once the queue is empty or about to be,
  // so loading the whole queue never overwrites a waiting result.
  always_ff @(posedge clk) begin
    if (accept) begin
      queue <= step_results;
    end else if (pop) begin
      for (int i = 0; i < icf_pkg::MAX_RESULTS - 1; i++) begin
        queue[i] <= queue[i+1];
      end
    end
  end

endmodule

// File: rtl/icf_step.sv
// Combinational step of the framer: next CRC/header state and the results of one byte.
// Depends on icf_pkg.
module icf_step (
  input  icf_pkg::state_t                 state,
  input  logic [7:0]                      in_byte,
  input  logic                            first_byte,
  input  logic                            last_byte,
  output icf_pkg::state_t                 state_next,
  output icf_pkg::result_t                results [icf_pkg::MAX_RESULTS],
  output logic [icf_pkg::QCNT_W-1:0]      num_results
);

  icf_pkg::state_t         s0;
  logic [23:0]             crc1;
  logic [23:0]             crc2;
  logic [23:0]             crc_inv;
  logic                    in_header;
  logic [icf_pkg::CNT_W-1:0] count_inc;
  logic [7:0]              parity_inc;
  logic                    ins_parity;
  logic [7:0]              parity_byte;

  always_comb begin
    if (first_byte) begin
      s0.crc    = icf_pkg::CRC_INIT;
      s0.parity = 8'h00;
      s0.count  = '0;
    end else begin
      s0 = state;
    end

    crc1        = icf_pkg::crc_fold(s0.crc, in_byte);
    in_header   = (s0.count < icf_pkg::HEADER_LEN);
    count_inc   = s0.count + icf_pkg::CNT_W'(1);
    parity_inc  = s0.parity ^ in_byte;
    ins_parity  = in_header && (count_inc == icf_pkg::HEADER_LEN);
    parity_byte = ~parity_inc;
    crc2        = ins_parity ? icf_pkg::crc_fold(crc1, parity_byte) : crc1;
    crc_inv     = ~crc2;

    state_next.crc    = crc2;
    state_next.parity = in_header ? parity_inc : s0.parity;
    state_next.count  = in_header ? count_inc : s0.count;

    for (int i = 0; i < icf_pkg::MAX_RESULTS; i++) begin
      results[i] = '0;
    end
    results[0] = '{data: in_byte, kind: icf_pkg::KIND_DATA, eom: 1'b0};

    if (ins_parity) begin
      results[1] = '{data: parity_byte, kind: icf_pkg::KIND_PARITY, eom: 1'b0};
      if (last_byte) begin
        results[2] = '{data: crc_inv[23:16], kind: icf_pkg::KIND_CRC, eom: 1'b0};
        results[3] = '{data: crc_inv[15:8],  kind: icf_pkg::KIND_CRC, eom: 1'b0};
        results[4] = '{data: crc_inv[7:0],   kind: icf_pkg::KIND_CRC, eom: 1'b1};
      end
    end else if (last_byte) begin
      results[1] = '{data: crc_inv[23:16], kind: icf_pkg::KIND_CRC, eom: 1'b0};
      results[2] = '{data: crc_inv[15:8],  kind: icf_pkg::KIND_CRC, eom: 1'b0};
      results[3] = '{data: crc_inv[7:0],   kind: icf_pkg::KIND_CRC, eom: 1'b1};
    end

    num_results = icf_pkg::QCNT_W'(1) + icf_pkg::QCNT_W'(ins_parity)
                + (last_byte ? icf_pkg::QCNT_W'(3) : icf_pkg::QCNT_W'(0));
  end

endmodule

// File: test/module_image_crc24_framer_test.sv
// Self-checking testbench for module_image_crc24_framer: checks pass-through bytes,
// inserted header parity and appended CRC-24 bytes against a built-in predictor.
// Depends on icf_pkg and the framer RTL; needs no files or arguments.
module module_image_crc24_framer_test;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
    int         nres;
    int         par;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       first_byte = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       end_of_module;

  // Predictor state and the bytes the block still owes us.
  logic [23:0]       crc_st;
  logic [7:0]        par_st;
  logic [3:0]        hdr_cnt;
  icf_pkg::result_t  framed_q[$];

  int mismatches = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_ticket = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  dir_row_t dir_tbl [0:22] = '{
    '{8'h00, 1'b0, 1'b0, 1, -1},
    '{8'hFF, 1'b0, 1'b0, 1, -1},
    '{8'h80, 1'b0, 1'b0, 1, -1},
    '{8'h7F, 1'b0, 1'b0, 1, -1},
    '{8'h01, 1'b0, 1'b0, 1, -1},
    '{8'hFE, 1'b0, 1'b0, 1, -1},
    '{8'h55, 1'b0, 1'b0, 1, -1},
    '{8'hAA, 1'b0, 1'b1, 5, 8'hFF},
    '{8'h5A, 1'b0, 1'b0, 1, -1},
    '{8'hA5, 1'b1, 1'b1, 4, -1},
    '{8'h3C, 1'b0, 1'b0, 1, -1},
    '{8'h7E, 1'b1, 1'b0, 1, -1},
    '{8'h81, 1'b0, 1'b1, 4, -1},
    '{8'h12, 1'b1, 1'b0, 1, -1},
    '{8'h34, 1'b0, 1'b0, 1, -1},
    '{8'h56, 1'b0, 1'b0, 1, -1},
    '{8'h78, 1'b0, 1'b0, 1, -1},
    '{8'h9A, 1'b0, 1'b0, 1, -1},
    '{8'hBC, 1'b0, 1'b0, 1, -1},
    '{8'hDE, 1'b0, 1'b0, 1, -1},
    '{8'hF0, 1'b0, 1'b0, 2, 8'hFF},
    '{8'h0F, 1'b0, 1'b0, 1, -1},
    '{8'hC3, 1'b0, 1'b1, 4, -1}
  };

  module_image_crc24_framer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .first_byte(first_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .byte_kind(byte_kind),
    .end_of_module(end_of_module)
  );

  always #5 clk = ~clk;

  function automatic logic [23:0] crc24_byte(input logic [23:0] c, input logic [7:0] b);
    logic [7:0] a;
    logic [7:0] p;
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] t2;
    a  = b ^ c[23:16];
    t0 = c[15:8];
    t1 = c[7:0] ^ (a >> 7) ^ (a >> 2);
    t2 = (a << 1) ^ (a << 6);
    // The top bit of the running XOR prefix decides the feedback taps.
    p = a ^ (a << 1);
    p = p ^ (p << 2);
    p = p ^ (p << 4);
    if (p[7]) begin
      t0 = t0 ^ 8'h80;
      t2 = t2 ^ 8'h21;
    end
    return {t0, t1, t2};
  endfunction

  function automatic icf_pkg::result_t mk_result(input logic [7:0] d, input logic [1:0] k,
                                                 input logic e);
    icf_pkg::result_t r;
    r.data = d;
    r.kind = k;
    r.eom  = e;
    return r;
  endfunction

  task automatic frame_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                            output int n);
    logic [23:0] inv;
    logic [7:0]  par;
    n = 1;
    if (is_first) begin
      crc_st  = icf_pkg::CRC_INIT;
      par_st  = 8'h00;
      hdr_cnt = '0;
    end
    framed_q.push_back(mk_result(b, icf_pkg::KIND_DATA, 1'b0));
    crc_st = crc24_byte(crc_st, b);
    if (hdr_cnt < icf_pkg::HEADER_LEN) begin
      par_st  = par_st ^ b;
      hdr_cnt = hdr_cnt + 4'd1;
      if (hdr_cnt == icf_pkg::HEADER_LEN) begin
        par = ~par_st;
        framed_q.push_back(mk_result(par, icf_pkg::KIND_PARITY, 1'b0));
        crc_st = crc24_byte(crc_st, par);
        n++;
      end
    end
    if (is_last) begin
      inv = ~crc_st;
      framed_q.push_back(mk_result(inv[23:16], icf_pkg::KIND_CRC, 1'b0));
      framed_q.push_back(mk_result(inv[15:8], icf_pkg::KIND_CRC, 1'b0));
      framed_q.push_back(mk_result(inv[7:0], icf_pkg::KIND_CRC, 1'b1));
      n += 3;
    end
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatches++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // Offers one byte, holding valid and payload until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                           output int n);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    first_byte <= is_first;
    last_byte  <= is_last;
    do @(posedge clk); while (!in_ready);
    frame_byte(b, is_first, is_last, n);
    items_sent++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed modules of random content, with stray bytes mixed in.
  task automatic run_random(input int target);
    int len;
    int n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(4, 1))
          send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                    $urandom_range(3) == 0, n);
      end else begin
        len = ($urandom_range(9) == 0) ? int'($urandom_range(40, 20))
                                       : int'($urandom_range(12, 1));
        for (int i = 0; i < len; i++)
          send_byte(8'($urandom_range(255)), i == 0, i == len - 1, n);
      end
    end
  endtask

  // Receiver: random back-pressure plus a long hold-off when hold_ticket is raised.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_ticket != hold_done) begin
      hold_done <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    icf_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (framed_q.size() == 0) begin
        note_mismatch("unexpected out_byte", -1, int'(out_byte));
      end else begin
        want = framed_q.pop_front();
        if (out_byte !== want.data)
          note_mismatch("out_byte", int'(want.data), int'(out_byte));
        if (byte_kind !== want.kind)
          note_mismatch("byte_kind", int'(want.kind), int'(byte_kind));
        if (end_of_module !== want.eom)
          note_mismatch("end_of_module", int'(want.eom), int'(end_of_module));
      end
    end
  end

  // Watchdog on cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    crc_st  = icf_pkg::CRC_INIT;
    par_st  = 8'h00;
    hdr_cnt = '0;
    tx_idle = 27;
    rx_idle = 65;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows start without a first byte, so reset state is in use.
    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].data, dir_tbl[i].is_first, dir_tbl[i].is_last, n);
      if (n != dir_tbl[i].nres) note_mismatch("result count", dir_tbl[i].nres, n);
      if (dir_tbl[i].par >= 0 &&
          int'(framed_q[framed_q.size() - n + 1].data) != dir_tbl[i].par)
        note_mismatch("parity byte", dir_tbl[i].par,
                      int'(framed_q[framed_q.size() - n + 1].data));
    end

    run_random(120);
    drain_all();

    tx_idle = 65;
    rx_idle = 27;
    run_random(215);
    drain_all();

    // Long receiver hold-off while bytes keep coming, so the input stalls.
    tx_idle = 0;
    rx_idle = 0;
    hold_ticket <= hold_ticket + 1;
    for (int i = 0; i < 20; i++)
      send_byte(8'($urandom_range(255)), i == 0, i == 19, n);
    run_random(310);
    drain_all();

    repeat (10) @(posedge clk);
    if (framed_q.size() != 0) note_mismatch("bytes still expected", 0, framed_q.size());
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: module_image_crc24_framer.f
rtl/icf_pkg.sv
rtl/icf_step.sv
rtl/module_image_crc24_framer.sv
test/module_image_crc24_framer_test.sv
